// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the credential table.
// Included by modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ctl_pkg.sv -----
// Package for the credential table: status codes, opcodes, sequencer states.
// No dependencies.
`timescale 1ns / 1ps
package ctl_pkg;
  localparam int unsigned MaxUsersDef    = 16;
  localparam int unsigned DigestWordsDef = 4;
  localparam logic [7:0]  MaxFailRst     = 8'd5;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SETEN  = 2'd2,
    OP_AUTH   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EXISTS    = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_DENIED    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CMP,
    S_CMPW,
    S_EXEC,
    S_OUT
  } state_e;
endpackage

// ----- rtl/credential_table_with_lockout.sv -----
// Top level of the credential table with failed-attempt lockout.
// Depends on ctl_pkg and assert_macros.svh.
//
// Channel  | Direction | Handshake      | Content
// in       | input     | valid / stall  | one command beat
// out      | output    | valid / stall  | status and entry fields
// cfg      | input     | valid / ready  | max_failures
//
// A non-final beat goes straight into staging. A final beat walks all MAX_USERS
// entries one per cycle through one id comparator, then execute and output
// follow. An authenticate that finds its user also reads the stored digest word
// by word, each read (S_CMP) followed by a compare (S_CMPW). After a successful
// add the input stays stalled until the digest copy after execute ends.
// Used and enabled marks are cleared by reset; other storage is not.
// The result waits in an output register until the output stall falls.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module credential_table_with_lockout
  import ctl_pkg::*;
#(
  parameter int unsigned MAX_USERS    = MaxUsersDef,
  parameter int unsigned DIGEST_WORDS = DigestWordsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] user_id_i,
  input  logic [31:0] group_id_i,
  input  logic [63:0] group_mask_i,
  input  logic [63:0] privilege_mask_i,
  input  logic [63:0] capability_mask_i,
  input  logic [63:0] digest_word_i,
  input  logic        enable_value_i,
  input  logic        last_beat_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] out_group_id_o,
  output logic [63:0] out_group_mask_o,
  output logic [63:0] out_privilege_mask_o,
  output logic [63:0] out_capability_mask_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);
  localparam int unsigned UW = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
  localparam int unsigned WW = (DIGEST_WORDS > 1) ? $clog2(DIGEST_WORDS) : 1;
  localparam int unsigned BW = $clog2(DIGEST_WORDS + 1);
  localparam int unsigned CW = $clog2(MAX_USERS + 1);
  localparam int unsigned DW = UW + WW;

  // Storage. Marks sit in flip-flops; the rest has no reset.
  // Each entry owns a power-of-two block of digest words.
  logic [MAX_USERS-1:0] used_q, enabled_q;
  logic [31:0] uid_mem [MAX_USERS];
  logic [31:0] gid_mem [MAX_USERS];
  logic [63:0] gmask_mem [MAX_USERS];
  logic [63:0] pmask_mem [MAX_USERS];
  logic [63:0] cmask_mem [MAX_USERS];
  logic [7:0]  fail_mem [MAX_USERS];
  logic [63:0] dig_mem [MAX_USERS*(2**WW)];
  logic [63:0] stage_q [DIGEST_WORDS];

  logic [7:0]    max_fail_q;
  logic [BW-1:0] beat_q, beat_d;
  state_e        state_q, state_d;
  logic [CW-1:0] scan_q, scan_d;
  logic          hit_q, hit_d, free_q, free_d;
  logic [UW-1:0] hit_idx_q, hit_idx_d, free_idx_q, free_idx_d;
  logic [BW-1:0] widx_q, widx_d;
  logic          diff_q, diff_d;
  logic [63:0]   rd_dig_q;
  logic [31:0]   rd_uid_q;

  // Command latched on the final beat.
  logic [1:0]  op_q;
  logic [31:0] uid_q, gid_q;
  logic [63:0] gmask_q, pmask_q, cmask_q;
  logic        en_q;
  logic [BW-1:0] nbeats_q;

  logic [2:0]  status_q, status_d;
  logic [31:0] ogid_q;
  logic [63:0] ogm_q, opm_q, ocm_q;
  logic        out_valid_q;

  logic in_xfer, out_xfer;
  logic [UW-1:0] scan_idx;
  logic [WW-1:0] w_idx;
  logic [DW-1:0] dig_addr;
  logic [63:0]   stage_word;

  // Digest copy state; the input waits while staging is still being copied.
  logic [BW-1:0] copy_q;
  logic          copy_act_q;

  assign in_stall_o  = (state_q != S_IDLE) || copy_act_q;
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_xfer    = out_valid_q && !out_stall_i;
  assign cfg_ready_o = (state_q == S_IDLE) && !out_valid_q;
  assign scan_idx    = scan_q[UW-1:0];
  assign w_idx       = widx_q[WW-1:0];
  assign dig_addr    = {hit_idx_q, w_idx};
  assign stage_word  = (widx_q < nbeats_q) ? stage_q[w_idx] : 64'd0;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_fail_q <= MaxFailRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_fail_q <= cfg_data_i;
    end
  end

  // Beat staging: words go to staging until it is full.
  always_comb begin
    beat_d = beat_q;
    if (in_xfer) begin
      if (last_beat_i) begin
        beat_d = '0;
      end else if (beat_q < BW'(DIGEST_WORDS)) begin
        beat_d = beat_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && beat_q < BW'(DIGEST_WORDS)) begin
      stage_q[beat_q[WW-1:0]] <= digest_word_i;
    end
    if (in_xfer && last_beat_i) begin
      op_q     <= opcode_i;
      uid_q    <= user_id_i;
      gid_q    <= group_id_i;
      gmask_q  <= group_mask_i;
      pmask_q  <= privilege_mask_i;
      cmask_q  <= capability_mask_i;
      en_q     <= enable_value_i;
      nbeats_q <= (beat_q < BW'(DIGEST_WORDS)) ? beat_q + 1'b1 : beat_q;
    end
    // Registered reads of the id table and digest memory.
    rd_uid_q <= uid_mem[scan_idx];
    rd_dig_q <= dig_mem[dig_addr];
  end

  // Sequencer: scan ids, compare digest words for an authenticate, then execute and output.
  always_comb begin
    state_d    = state_q;
    scan_d     = scan_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    widx_d     = widx_q;
    diff_d     = diff_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer && last_beat_i) begin
          state_d = S_SCAN;
          scan_d  = '0;
          hit_d   = 1'b0;
          free_d  = 1'b0;
        end
      end
      S_SCAN: begin
        // rd_uid_q holds the id of entry scan_q - 1 from the previous cycle.
        if (scan_q != '0) begin
          if (!hit_d && used_q[scan_idx - 1'b1] && rd_uid_q == uid_q) begin
            hit_d     = 1'b1;
            hit_idx_d = scan_idx - 1'b1;
          end
          if (!free_d && !used_q[scan_idx - 1'b1]) begin
            free_d     = 1'b1;
            free_idx_d = scan_idx - 1'b1;
          end
        end
        if (scan_q == CW'(MAX_USERS)) begin
          widx_d  = '0;
          diff_d  = 1'b0;
          state_d = (op_q == OP_AUTH && hit_d) ? S_CMP : S_EXEC;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      S_CMP: begin
        // Read issued for word widx_q; compare on the next cycle.
        state_d = S_CMPW;
      end
      S_CMPW: begin
        diff_d = diff_q | (rd_dig_q != stage_word);
        if (widx_q == BW'(DIGEST_WORDS - 1)) begin
          state_d = S_EXEC;
        end else begin
          widx_d  = widx_q + 1'b1;
          state_d = S_CMP;
        end
      end
      S_EXEC: state_d = S_OUT;
      S_OUT: begin
        if (!out_valid_q || out_xfer) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer and beat count registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      beat_q  <= '0;
      scan_q  <= '0;
      hit_q   <= 1'b0;
      free_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      beat_q  <= beat_d;
      scan_q  <= scan_d;
      hit_q   <= hit_d;
      free_q  <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    widx_q     <= widx_d;
    diff_q     <= diff_d;
  end

  // Execute: decide status and update the table.
  logic       fail_lock;
  logic [7:0] fail_cur, fail_inc;
  assign fail_cur  = fail_mem[hit_idx_q];
  assign fail_inc  = (fail_cur == 8'hFF) ? fail_cur : fail_cur + 8'd1;
  assign fail_lock = fail_cur >= max_fail_q;

  always_comb begin
    status_d = ST_OK;
    unique case (op_q)
      OP_ADD:    status_d = hit_q ? ST_EXISTS : (free_q ? ST_OK : ST_FULL);
      OP_REMOVE: status_d = hit_q ? ST_OK : ST_NOT_FOUND;
      OP_SETEN:  status_d = hit_q ? ST_OK : ST_NOT_FOUND;
      OP_AUTH: begin
        if (!hit_q || !enabled_q[hit_idx_q] || fail_lock || diff_q) begin
          status_d = ST_DENIED;
        end
      end
      default: status_d = ST_OK;
    endcase
  end

  logic auth_ok, auth_bad, exec;
  assign exec     = (state_q == S_EXEC);
  assign auth_ok  = op_q == OP_AUTH && hit_q && enabled_q[hit_idx_q] && !fail_lock && !diff_q;
  assign auth_bad = op_q == OP_AUTH && hit_q && enabled_q[hit_idx_q] && !fail_lock && diff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      enabled_q <= '0;
    end else if (exec) begin
      if (op_q == OP_ADD && !hit_q && free_q) begin
        used_q[free_idx_q]    <= 1'b1;
        enabled_q[free_idx_q] <= 1'b1;
      end else if (op_q == OP_REMOVE && hit_q) begin
        used_q[hit_idx_q]    <= 1'b0;
        enabled_q[hit_idx_q] <= 1'b0;
      end else if (op_q == OP_SETEN && hit_q) begin
        enabled_q[hit_idx_q] <= en_q;
      end else if (auth_bad && fail_inc >= max_fail_q) begin
        enabled_q[hit_idx_q] <= 1'b0;
      end
    end
  end

  // Entry payload writes; the digest words go in one per cycle over the
  // cycles after execute, through a small copy counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      copy_act_q <= 1'b0;
      copy_q     <= '0;
    end else if (exec && op_q == OP_ADD && !hit_q && free_q) begin
      copy_act_q <= 1'b1;
      copy_q     <= '0;
    end else if (copy_act_q) begin
      copy_q <= copy_q + 1'b1;
      if (copy_q == BW'(DIGEST_WORDS - 1)) copy_act_q <= 1'b0;
    end
  end

  logic [63:0] copy_word;
  assign copy_word = (copy_q < nbeats_q) ? stage_q[copy_q[WW-1:0]] : 64'd0;

  always_ff @(posedge clk_i) begin
    if (copy_act_q) begin
      dig_mem[{free_idx_q, copy_q[WW-1:0]}] <= copy_word;
    end
    if (exec) begin
      if (op_q == OP_ADD && !hit_q && free_q) begin
        uid_mem[free_idx_q]   <= uid_q;
        gid_mem[free_idx_q]   <= gid_q;
        gmask_mem[free_idx_q] <= gmask_q;
        pmask_mem[free_idx_q] <= pmask_q;
        cmask_mem[free_idx_q] <= cmask_q;
        fail_mem[free_idx_q]  <= 8'd0;
      end else if (op_q == OP_SETEN && hit_q && en_q) begin
        fail_mem[hit_idx_q] <= 8'd0;
      end else if (auth_ok) begin
        fail_mem[hit_idx_q] <= 8'd0;
      end else if (auth_bad) begin
        fail_mem[hit_idx_q] <= fail_inc;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec) begin
      out_valid_q <= 1'b1;
    end else if (out_xfer) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      status_q <= status_d;
      ogid_q   <= auth_ok ? gid_mem[hit_idx_q]   : 32'd0;
      ogm_q    <= auth_ok ? gmask_mem[hit_idx_q] : 64'd0;
      opm_q    <= auth_ok ? pmask_mem[hit_idx_q] : 64'd0;
      ocm_q    <= auth_ok ? cmask_mem[hit_idx_q] : 64'd0;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign status_o              = status_q;
  assign out_group_id_o        = ogid_q;
  assign out_group_mask_o      = ogm_q;
  assign out_privilege_mask_o  = opm_q;
  assign out_capability_mask_o = ocm_q;

  // Assertions.
  `ASSERT_NEXT(a_exec_out, clk_i, rst_ni, exec, out_valid_q, "exec without result")
  `ASSERT_IMPL(a_no_in_busy, clk_i, rst_ni, state_q != S_IDLE, in_stall_o, "input open while busy")
  `ASSERT_IMPL(a_ok_hit, clk_i, rst_ni, exec && auth_ok, status_d == ST_OK, "auth ok mismatch")
  `ASSERT_IMPL(a_beat_max, clk_i, rst_ni, 1'b1, beat_q <= BW'(DIGEST_WORDS), "beat count overflow")
endmodule
